[hdl/mos_pkg.sv]
// ----------------------------------------------------------------------------
// mos_pkg
// Shared types and constants for the median-of-sample-set block.
// ----------------------------------------------------------------------------
package mos_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 7;

    // Sequencer states of the sorted store
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MED_RD0,
        ST_MED_RD1,
        ST_MED_CALC
    } t_state;

    // One finished median, handed from the store to the output register
    typedef struct packed {
        logic [SAMPLE_W-1:0] median_value;
        logic [COUNT_W-1:0]  sample_count;
        logic                overflowed;
    } t_result;

endpackage

[hdl/median_of_sample_set.sv]
// ----------------------------------------------------------------------------
// median_of_sample_set
// Loads a set of unsigned samples into a sorted store and gives its median.
// ----------------------------------------------------------------------------
// Samples are kept in ascending order in a single-port-read memory; each one
// is placed by insertion, moving every larger stored entry up one place at one
// entry per cycle. After the closing sample the two middle entries are read
// and the median is formed; it then sits in an output register while the
// next set starts loading. Sets with more than MaxSamples samples keep the
// first MaxSamples and report overflow. The memory needs no clearing pass.
module median_of_sample_set #(
    parameter int MaxSamples = mos_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [mos_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [mos_pkg::SAMPLE_W-1:0]  o_median_value,
    output logic [mos_pkg::COUNT_W-1:0]   o_sample_count,
    output logic                          o_overflowed
);
    import mos_pkg::*;

    logic    res_valid;
    logic    res_stall;
    t_result res;
    logic    r_o_valid;
    t_result r_o_res;

    mos_store #(
        .MaxSamples(MaxSamples)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_sample     (i_sample),
        .i_last_sample(i_last_sample),
        .o_stall      (o_stall),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_stall  (res_stall)
    );

    // Hold the store while the output register is full and not taken
    assign res_stall = r_o_valid && i_stall;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!res_stall) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!res_stall && res_valid) begin
            r_o_res <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_median_value = r_o_res.median_value;
    assign o_sample_count = r_o_res.sample_count;
    assign o_overflowed   = r_o_res.overflowed;

endmodule

[hdl/mos_store.sv]
// ----------------------------------------------------------------------------
// mos_store
// Sorted sample memory with insertion sequencer and median read-out.
// ----------------------------------------------------------------------------
module mos_store #(
    parameter int MaxSamples = mos_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mos_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_last_sample,
    output logic                          o_stall,
    output logic                          o_res_valid,
    output mos_pkg::t_result              o_res,
    input  logic                          i_res_stall
);
    import mos_pkg::*;

    localparam int AW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
    localparam int CW = $clog2(MaxSamples + 1);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic                  r_ovf;
    logic [AW-1:0]         r_pos;
    logic [SAMPLE_W-1:0]   r_val;
    logic                  r_last;
    logic [SAMPLE_W-1:0]   r_rd_data;
    logic [SAMPLE_W-1:0]   r_lo_data;
    logic [SAMPLE_W-1:0]   r_mem [MaxSamples];

    logic                  accept;
    logic                  room;
    logic                  greater;
    logic                  shift_step;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [SAMPLE_W-1:0]   wr_data;
    logic [AW-1:0]         lo_addr;
    logic [AW-1:0]         hi_addr;
    logic [CW-1:0]         count_m1;
    logic [SAMPLE_W:0]     pair_sum;

    assign accept     = (r_state == ST_IDLE) && i_valid;
    assign room       = r_count < CW'(MaxSamples);
    assign greater    = r_rd_data > r_val;
    assign shift_step = (r_pos != '0) && greater;
    assign count_m1   = r_count - 1'b1;
    assign lo_addr    = AW'(count_m1 >> 1);
    assign hi_addr    = AW'(r_count >> 1);
    assign pair_sum   = {1'b0, r_lo_data} + {1'b0, r_rd_data};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && room) begin
                    n_state = ST_SHIFT;
                end else if (accept && i_last_sample) begin
                    n_state = ST_MED_RD0;
                end
            end
            ST_SHIFT: begin
                if (!shift_step) begin
                    n_state = r_last ? ST_MED_RD0 : ST_IDLE;
                end
            end
            ST_MED_RD0: n_state = ST_MED_RD1;
            ST_MED_RD1: n_state = ST_MED_CALC;
            ST_MED_CALC: begin
                if (!i_res_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory strobes and result valid
    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_val;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // fetch the current top entry for the first compare
                rd_en   = accept && room && (r_count != '0);
                rd_addr = AW'(count_m1);
            end
            ST_SHIFT: begin
                wr_en = 1'b1;
                if (shift_step) begin
                    // move the larger entry up one place, fetch the next one down
                    wr_data = r_rd_data;
                    rd_en   = 1'b1;
                    rd_addr = r_pos - AW'(2);
                end
            end
            ST_MED_RD0: begin
                rd_en   = 1'b1;
                rd_addr = lo_addr;
            end
            ST_MED_RD1: begin
                rd_en   = 1'b1;
                rd_addr = hi_addr;
            end
            ST_MED_CALC: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_stall             = (r_state != ST_IDLE);
    assign o_res.median_value  = pair_sum[SAMPLE_W:1];
    assign o_res.sample_count  = COUNT_W'(r_count);
    assign o_res.overflowed    = r_ovf;

    // Sample memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && !room) begin
                r_ovf <= 1'b1;
            end
            if ((r_state == ST_SHIFT) && !shift_step) begin
                r_count <= r_count + 1'b1;
            end
            // close the set once the result is handed on
            if ((r_state == ST_MED_CALC) && !i_res_stall) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // Working registers of the current transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val  <= i_sample;
            r_last <= i_last_sample;
            r_pos  <= AW'(r_count);
        end else if ((r_state == ST_SHIFT) && shift_step) begin
            r_pos <= r_pos - 1'b1;
        end
        if (r_state == ST_MED_RD1) begin
            r_lo_data <= r_rd_data;
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for median_of_sample_set. Sample sets of many sizes and
// value shapes are streamed in, including sets that overrun the store. A
// scoreboard keeps its own sorted copy of each set, predicts the median,
// count and overflow flag, and compares every result transfer in order.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import mos_pkg::*;

    localparam int CAPACITY       = MAX_SAMPLES_DEF;
    localparam int RANDOM_SAMPLES = 1900;
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 40;
    localparam int OPENING_COUNT  = 19;

    // Opening sets: bit 16 flags the closing sample of a set
    localparam logic [SAMPLE_W:0] OPENING_ITEMS [OPENING_COUNT] = '{
        {1'b1, 16'h0000},
        {1'b1, 16'hFFFF},
        {1'b0, 16'hFFFF}, {1'b1, 16'hFFFF},
        {1'b0, 16'h0000}, {1'b1, 16'hFFFF},
        {1'b0, 16'd300},  {1'b0, 16'd200},  {1'b1, 16'd100},
        {1'b0, 16'd7},    {1'b0, 16'd7},    {1'b0, 16'd9},   {1'b1, 16'd1},
        {1'b0, 16'hAAAA}, {1'b1, 16'h5555},
        {1'b0, 16'd4},    {1'b0, 16'd1},    {1'b0, 16'd8},   {1'b1, 16'd3}
    };

    // Value shapes for the random sets
    typedef enum int {
        PAT_UNIFORM,
        PAT_CLUSTER,
        PAT_FLAT,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREME
    } t_pattern;

    // Sorted copy of the current set and the queue of medians still owed
    class median_scoreboard;
        logic [SAMPLE_W-1:0] sorted_set [CAPACITY];
        int unsigned         kept;
        bit                  dropped;
        t_result             owed_medians [$];
        int unsigned         errors;
        int unsigned         sets_closed;
        int unsigned         overflow_sets;

        function new();
            kept          = 0;
            dropped       = 1'b0;
            errors        = 0;
            sets_closed   = 0;
            overflow_sets = 0;
        endfunction

        // Insert an accepted sample; on the closing one, queue the median
        function void note_sample(logic [SAMPLE_W-1:0] value, logic last);
            int unsigned       pos;
            logic [SAMPLE_W:0] pair_sum;
            t_result           med;
            if (kept < CAPACITY) begin
                pos = kept;
                while (pos > 0 && sorted_set[pos-1] > value) begin
                    sorted_set[pos] = sorted_set[pos-1];
                    pos--;
                end
                sorted_set[pos] = value;
                kept++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                if (kept[0]) begin
                    med.median_value = sorted_set[kept/2];
                end else begin
                    pair_sum = {1'b0, sorted_set[kept/2-1]} + {1'b0, sorted_set[kept/2]};
                    med.median_value = pair_sum[SAMPLE_W:1];
                end
                med.sample_count = COUNT_W'(kept);
                med.overflowed   = dropped;
                owed_medians.insert(owed_medians.size(), med);
                sets_closed++;
                if (dropped)
                    overflow_sets++;
                kept    = 0;
                dropped = 1'b0;
            end
        endfunction

        // Compare one result transfer with the oldest owed median
        function void check_median(logic [SAMPLE_W-1:0] value, logic [COUNT_W-1:0] count,
                                   logic ovf);
            t_result want;
            if (owed_medians.size() == 0) begin
                $display("%0t: result with none owed: median %0d count %0d overflowed %0b",
                         $time, value, count, ovf);
                errors++;
                return;
            end
            want = owed_medians.pop_front();
            if (value !== want.median_value) begin
                $display("%0t: median_value expected %0d actual %0d",
                         $time, want.median_value, value);
                errors++;
            end
            if (count !== want.sample_count) begin
                $display("%0t: sample_count expected %0d actual %0d",
                         $time, want.sample_count, count);
                errors++;
            end
            if (ovf !== want.overflowed) begin
                $display("%0t: overflowed expected %0b actual %0b",
                         $time, want.overflowed, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_last_sample;
    logic                o_valid;
    logic                i_stall;
    logic [SAMPLE_W-1:0] o_median_value;
    logic [COUNT_W-1:0]  o_sample_count;
    logic                o_overflowed;

    median_scoreboard board;
    int unsigned      samples_sent;
    int unsigned      largest_set;

    median_of_sample_set #(
        .MaxSamples(CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_median_value(o_median_value),
        .o_sample_count(o_sample_count),
        .o_overflowed  (o_overflowed)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #10_000_000;
        $display("** median_of_sample_set: FAILED **");
        $finish;
    end

    // Hold off for the gap, then offer one sample until it is transferred
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last,
                               input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= value;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_sample(value, last);
        samples_sent++;
    endtask

    // Drop valid and wait until every owed median has been transferred
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.owed_medians.size() != 0);
    endtask

    // Stream one set of the given size and shape
    task automatic send_set(input int set_size, input t_pattern pattern, input bit burst);
        int                  idx;
        int                  stride;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] value;
        base   = SAMPLE_W'($urandom_range(0, 65535));
        stride = $urandom_range(1, 900);
        for (idx = 0; idx < set_size; idx++) begin
            case (pattern)
                PAT_UNIFORM: value = SAMPLE_W'($urandom_range(0, 65535));
                PAT_CLUSTER: value = base + SAMPLE_W'($urandom_range(0, 7));
                PAT_FLAT:    value = base;
                PAT_RISING:  value = base + SAMPLE_W'(idx * stride);
                PAT_FALLING: value = base - SAMPLE_W'(idx * stride);
                default:     value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            endcase
            send_sample(value, idx == set_size - 1, burst ? 0 : $urandom_range(0, 14));
        end
        if (set_size > largest_set)
            largest_set = set_size;
    endtask

    // Result side: stall for a random spell before each transfer, except in calm spells
    initial begin : result_sink
        int hold;
        bit calm;
        calm = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            hold = calm ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(i_rst_n && o_valid && !i_stall));
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_median(o_median_value, o_sample_count, o_overflowed);
    end

    // Reset, opening sets, then random sets
    initial begin : stimulus
        int          idx;
        int          pick;
        int          set_size;
        int unsigned phase_start;
        t_pattern    pattern;
        bit          burst;
        board        = new();
        samples_sent = 0;
        largest_set  = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_sample      <= '0;
        i_last_sample <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes, even and odd counts, duplicates and truncated averages
        for (idx = 0; idx < OPENING_COUNT; idx++)
            send_sample(OPENING_ITEMS[idx][SAMPLE_W-1:0], OPENING_ITEMS[idx][SAMPLE_W],
                        $urandom_range(0, 14));
        if (largest_set < 4)
            largest_set = 4;
        drain_results();

        // Mostly small sets; some fill the store exactly or overrun it
        phase_start = samples_sent;
        while (samples_sent - phase_start < RANDOM_SAMPLES) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                set_size = $urandom_range(1, 8);
            else if (pick < 80)
                set_size = $urandom_range(9, 40);
            else if (pick < 88)
                set_size = $urandom_range(41, CAPACITY - 1);
            else if (pick < 92)
                set_size = CAPACITY;
            else if (pick < 96)
                set_size = CAPACITY + 1;
            else
                set_size = $urandom_range(CAPACITY + 2, CAPACITY + 26);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                pattern = PAT_UNIFORM;
            else
                pattern = t_pattern'(pick - 4);
            burst = ($urandom_range(0, 3) == 0);
            send_set(set_size, pattern, burst);
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end

        // Let the last medians out, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Streamed %0d samples in %0d sets, largest %0d samples.",
                 samples_sent, board.sets_closed, largest_set);
        $display("%0d sets overran the store of %0d entries.",
                 board.overflow_sets, CAPACITY);
        if (board.errors == 0 && board.owed_medians.size() == 0) begin
            $display("** median_of_sample_set: PASSED **");
        end else begin
            $display("** median_of_sample_set: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/mos_pkg.sv
hdl/mos_store.sv
hdl/median_of_sample_set.sv
sim/testbench.sv
